@@ hdl/lc3b_pkg.sv @@
`timescale 1ns / 1ps
package lc3b_pkg;

	localparam int MEM_WORDS_DEF = 32768;
	localparam int NUM_REGS = 8;

	localparam logic [2:0] FLAGS_N = 3'b100;
	localparam logic [2:0] FLAGS_Z = 3'b010;
	localparam logic [2:0] FLAGS_P = 3'b001;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_SETPC = 2'd2,
		REQ_EXEC  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DEC,
		ST_EX,
		ST_MEM,
		ST_FIN
	} state_t;

	localparam logic [3:0] OP_BR   = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_LDB  = 4'd2;
	localparam logic [3:0] OP_STB  = 4'd3;
	localparam logic [3:0] OP_JSR  = 4'd4;
	localparam logic [3:0] OP_AND  = 4'd5;
	localparam logic [3:0] OP_LDW  = 4'd6;
	localparam logic [3:0] OP_STW  = 4'd7;
	localparam logic [3:0] OP_XOR  = 4'd9;
	localparam logic [3:0] OP_JMP  = 4'd12;
	localparam logic [3:0] OP_SHF  = 4'd13;
	localparam logic [3:0] OP_LEA  = 4'd14;
	localparam logic [3:0] OP_TRAP = 4'd15;

	localparam logic [2:0] LINK_REG = 3'd7;

	typedef struct packed {
		logic        wr;
		logic [2:0]  dr;
		logic [15:0] rv;
		logic        set_cc;
		logic [15:0] npc;
		logic [15:0] ea;
		logic        need_mem;
		logic        st_word;
	} exec_t;

	function automatic logic [2:0] cc_of(input logic [15:0] v);
		if (v[15])
			return FLAGS_N;
		else if (v == 16'd0)
			return FLAGS_Z;
		else
			return FLAGS_P;
	endfunction

	// word address reduced into the memory; depth is at least 256, so the
	// quotient of a 15-bit address fits in seven bits
	function automatic logic [14:0] word_mod(input logic [14:0] a, input int m);
		logic [14:0] r;
		r = a;
		for (int k = 6; k >= 0; k--) begin
			if (32'(r) >= (m << k))
				r = r - 15'(m << k);
		end
		return r;
	endfunction

endpackage

@@ hdl/lc3b_mem.sv @@
`timescale 1ns / 1ps
module lc3b_mem #(
	parameter int MEM_WORDS = lc3b_pkg::MEM_WORDS_DEF
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(MEM_WORDS)-1:0] waddr,
	input  logic [15:0]                  wdata,
	input  logic                         re,
	input  logic [$clog2(MEM_WORDS)-1:0] raddr,
	output logic [15:0]                  rdata
);

	logic [15:0] mem [MEM_WORDS];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

@@ hdl/lc3b_rf.sv @@
`timescale 1ns / 1ps
module lc3b_rf (
	input  logic        clk,
	input  logic        we,
	input  logic [2:0]  waddr,
	input  logic [15:0] wdata,
	input  logic        re,
	input  logic [2:0]  raddr_a,
	input  logic [2:0]  raddr_b,
	output logic [15:0] rdata_a,
	output logic [15:0] rdata_b
);

	import lc3b_pkg::*;

	logic [15:0] regs [NUM_REGS];

	always_ff @(posedge clk) begin
		if (we)
			regs[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= regs[raddr_a];
			rdata_b <= regs[raddr_b];
		end
	end

endmodule

@@ hdl/lc3b_alu.sv @@
`timescale 1ns / 1ps
module lc3b_alu (
	input  logic [15:0]     ir,
	input  logic [15:0]     pc,
	input  logic [15:0]     s1,
	input  logic [15:0]     s2,
	input  logic [15:0]     trap_vec,
	input  logic [2:0]      flags,
	output lc3b_pkg::exec_t ex
);

	import lc3b_pkg::*;

	logic [3:0]  op;
	logic [15:0] npc;
	logic [15:0] opnd;
	logic [15:0] off6;
	logic [15:0] off6w;
	logic [15:0] off9;
	logic [15:0] off11;

	always_comb begin
		op    = ir[15:12];
		npc   = pc + 16'd2;
		opnd  = ir[5] ? {{11{ir[4]}}, ir[4:0]} : s2;
		off6  = {{10{ir[5]}}, ir[5:0]};
		off6w = {{9{ir[5]}}, ir[5:0], 1'b0};
		off9  = {{6{ir[8]}}, ir[8:0], 1'b0};
		off11 = {{4{ir[10]}}, ir[10:0], 1'b0};

		ex     = '0;
		ex.dr  = ir[11:9];
		ex.npc = npc;

		case (op)
			OP_ADD: begin
				ex.wr = 1'b1; ex.set_cc = 1'b1; ex.rv = s1 + opnd;
			end
			OP_AND: begin
				ex.wr = 1'b1; ex.set_cc = 1'b1; ex.rv = s1 & opnd;
			end
			OP_XOR: begin
				ex.wr = 1'b1; ex.set_cc = 1'b1; ex.rv = s1 ^ opnd;
			end
			OP_SHF: begin
				ex.wr = 1'b1; ex.set_cc = 1'b1;
				if (!ir[4])
					ex.rv = s1 << ir[3:0];
				else if (!ir[5])
					ex.rv = s1 >> ir[3:0];
				else
					ex.rv = 16'($signed(s1) >>> ir[3:0]);
			end
			OP_BR: begin
				if ((ir[11:9] & flags) != 3'd0)
					ex.npc = npc + off9;
			end
			OP_JMP: begin
				ex.npc = s1;
			end
			OP_JSR: begin
				ex.wr = 1'b1; ex.dr = LINK_REG; ex.rv = npc;
				ex.npc = ir[11] ? npc + off11 : s1;
			end
			OP_LEA: begin
				ex.wr = 1'b1; ex.rv = npc + off9;
			end
			OP_LDB: begin
				ex.wr = 1'b1; ex.set_cc = 1'b1; ex.need_mem = 1'b1; ex.ea = s1 + off6;
			end
			OP_LDW: begin
				ex.wr = 1'b1; ex.set_cc = 1'b1; ex.need_mem = 1'b1; ex.ea = s1 + off6w;
			end
			OP_STB: begin
				ex.need_mem = 1'b1; ex.ea = s1 + off6;
			end
			OP_STW: begin
				ex.st_word = 1'b1; ex.ea = s1 + off6w;
			end
			OP_TRAP: begin
				ex.wr = 1'b1; ex.dr = LINK_REG; ex.rv = npc; ex.npc = trap_vec;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hdl/lc3b_instruction_step.sv @@
`timescale 1ns / 1ps
// Sequence: memory write, memory read, set pc and halt go from idle straight to
// the finish state; ALU, branch, jump, LEA, STW and TRAP pass through decode and
// execute; loads and STB add a memory state (extra data memory access).
// Overlap: the result transfer shares its cycle with the next request's start
// unless out_stall holds the output; fetch, trap vector and data reads use the
// one read port of the main memory. Reset: after arst_n releases, a clearing
// pass zeroes memory and registers; in_stall is high until it ends.
module lc3b_instruction_step #(
	parameter int MEM_WORDS = lc3b_pkg::MEM_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [14:0] mem_addr,
	input  logic [15:0] mem_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pc_now,
	output logic [2:0]  cond_flags,
	output logic        reg_written,
	output logic [2:0]  reg_index,
	output logic [15:0] reg_value,
	output logic [15:0] read_data,
	output logic        halted
);

	import lc3b_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

	state_t state_q, state_nxt;

	logic [AW-1:0] clr_q;
	logic          inb_v_q;
	req_t          inb_req_q;
	logic [14:0]   inb_addr_q;
	logic [15:0]   inb_data_q;
	logic [15:0]   pc_q;
	logic [2:0]    flags_q;
	logic [15:0]   ir_q;
	logic          ea0_q;
	logic [AW-1:0] maddr_q;
	logic          res_wr_q;
	logic [2:0]    res_idx_q;
	logic [15:0]   res_val_q;
	logic [15:0]   res_rdata_q;
	logic          res_rd_mem_q;
	logic          res_halt_q;
	logic          out_valid_q;

	logic          out_free, start, push;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [15:0]   mem_wdata, mem_rd;
	logic          rf_we, rf_re;
	logic [2:0]    rf_waddr, rf_raddr_b;
	logic [15:0]   rf_wdata, rf_a, rf_b;
	logic [14:0]   req_w15, pc_w15, ea_w15;
	logic [15:0]   ld_val, stb_word;
	logic [7:0]    ld_byte;
	logic [3:0]    dec_op, ir_op;
	exec_t         ex;

	lc3b_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rd)
	);

	lc3b_rf u_rf (
		.clk     (clk),
		.we      (rf_we),
		.waddr   (rf_waddr),
		.wdata   (rf_wdata),
		.re      (rf_re),
		.raddr_a (mem_rd[8:6]),
		.raddr_b (rf_raddr_b),
		.rdata_a (rf_a),
		.rdata_b (rf_b)
	);

	lc3b_alu u_alu (
		.ir       (ir_q),
		.pc       (pc_q),
		.s1       (rf_a),
		.s2       (rf_b),
		.trap_vec (mem_rd),
		.flags    (flags_q),
		.ex       (ex)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign start    = inb_v_q && (state_q == ST_IDLE || (state_q == ST_FIN && out_free));
	assign in_stall = (state_q == ST_CLEAR) || (inb_v_q && !start);

	always_comb begin
		req_w15 = word_mod(inb_addr_q, MEM_WORDS);
		pc_w15  = word_mod(pc_q[15:1], MEM_WORDS);
		ea_w15  = word_mod(ex.ea[15:1], MEM_WORDS);
		dec_op  = mem_rd[15:12];
		ir_op   = ir_q[15:12];
		ld_byte = ea0_q ? mem_rd[15:8] : mem_rd[7:0];
		ld_val  = (ir_op == OP_LDB) ? {{8{ld_byte[7]}}, ld_byte} : mem_rd;
		stb_word = ea0_q ? {rf_b[7:0], mem_rd[7:0]} : {mem_rd[15:8], rf_b[7:0]};
		rf_raddr_b = (dec_op == OP_STB || dec_op == OP_STW) ? mem_rd[11:9] : mem_rd[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		push      = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = maddr_q;
		mem_wdata = stb_word;
		mem_re    = 1'b0;
		mem_raddr = ea_w15[AW-1:0];
		rf_we     = 1'b0;
		rf_re     = 1'b0;
		rf_waddr  = ex.dr;
		rf_wdata  = ex.rv;

		if (state_q == ST_FIN && out_free) begin
			push      = 1'b1;
			state_nxt = ST_IDLE;
		end

		if (start) begin
			case (inb_req_q)
				REQ_WRITE: begin
					mem_we    = 1'b1;
					mem_waddr = req_w15[AW-1:0];
					mem_wdata = inb_data_q;
					state_nxt = ST_FIN;
				end
				REQ_READ: begin
					mem_re    = 1'b1;
					mem_raddr = req_w15[AW-1:0];
					state_nxt = ST_FIN;
				end
				REQ_SETPC: begin
					state_nxt = ST_FIN;
				end
				REQ_EXEC: begin
					if (pc_q == 16'd0) begin
						state_nxt = ST_FIN;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = pc_w15[AW-1:0];
						state_nxt = ST_DEC;
					end
				end
				default: begin
					state_nxt = ST_FIN;
				end
			endcase
		end

		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 16'd0;
				rf_we     = (32'(clr_q) < NUM_REGS);
				rf_waddr  = clr_q[2:0];
				rf_wdata  = 16'd0;
				if (clr_q == LAST_ADDR)
					state_nxt = ST_IDLE;
			end
			ST_DEC: begin
				rf_re = 1'b1;
				if (dec_op == OP_TRAP) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(mem_rd[7:0]);
				end
				state_nxt = ST_EX;
			end
			ST_EX: begin
				if (ex.need_mem) begin
					mem_re    = 1'b1;
					mem_raddr = ea_w15[AW-1:0];
					state_nxt = ST_MEM;
				end else begin
					rf_we     = ex.wr;
					state_nxt = ST_FIN;
				end
				if (ex.st_word) begin
					mem_we    = 1'b1;
					mem_waddr = ea_w15[AW-1:0];
					mem_wdata = rf_b;
				end
			end
			ST_MEM: begin
				if (ir_op == OP_STB)
					mem_we = 1'b1;
				rf_we     = (ir_op == OP_LDB || ir_op == OP_LDW);
				rf_waddr  = ir_q[11:9];
				rf_wdata  = ld_val;
				state_nxt = ST_FIN;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			inb_v_q     <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= 16'd0;
			flags_q     <= FLAGS_Z;
		end else begin
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + AW'(1);

			if (in_valid && !in_stall)
				inb_v_q <= 1'b1;
			else if (start)
				inb_v_q <= 1'b0;

			if (push)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			if (start && inb_req_q == REQ_SETPC) begin
				pc_q    <= inb_data_q;
				flags_q <= FLAGS_Z;
			end

			if (state_q == ST_EX) begin
				pc_q <= ex.npc;
				if (!ex.need_mem && ex.set_cc)
					flags_q <= cc_of(ex.rv);
			end

			if (state_q == ST_MEM && (ir_op == OP_LDB || ir_op == OP_LDW))
				flags_q <= cc_of(ld_val);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			inb_req_q  <= req_t'(req_type);
			inb_addr_q <= mem_addr;
			inb_data_q <= mem_data;
		end

		if (start) begin
			res_wr_q     <= 1'b0;
			res_idx_q    <= 3'd0;
			res_val_q    <= 16'd0;
			res_rdata_q  <= 16'd0;
			res_rd_mem_q <= (inb_req_q == REQ_READ);
			res_halt_q   <= (inb_req_q == REQ_EXEC) && (pc_q == 16'd0);
		end

		case (state_q)
			ST_DEC: begin
				ir_q        <= mem_rd;
				res_rdata_q <= mem_rd;
			end
			ST_EX: begin
				ea0_q   <= ex.ea[0];
				maddr_q <= ea_w15[AW-1:0];
				if (ex.wr) begin
					res_wr_q  <= 1'b1;
					res_idx_q <= ex.dr;
					res_val_q <= ex.rv;
				end
			end
			ST_MEM: begin
				if (ir_op == OP_LDB || ir_op == OP_LDW)
					res_val_q <= ld_val;
			end
			default: begin
			end
		endcase

		if (push) begin
			pc_now      <= pc_q;
			cond_flags  <= flags_q;
			reg_written <= res_wr_q;
			reg_index   <= res_idx_q;
			reg_value   <= res_val_q;
			read_data   <= res_rd_mem_q ? mem_rd : res_rdata_q;
			halted      <= res_halt_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import lc3b_pkg::*;

	localparam int MEM_WORDS = lc3b_pkg::MEM_WORDS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 256;

	// opcodes with no defined effect beyond advancing the pc
	localparam logic [3:0] OP_RTI = 4'd8;
	localparam logic [3:0] OP_RSV_A = 4'd10;
	localparam logic [3:0] OP_RSV_B = 4'd11;

	typedef struct packed {
		logic [15:0] pc_now;
		logic [2:0]  cond_flags;
		logic        reg_written;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
		logic [15:0] read_data;
		logic        halted;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [14:0] mem_addr;
	logic [15:0] mem_data;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] pc_now;
	logic [2:0]  cond_flags;
	logic        reg_written;
	logic [2:0]  reg_index;
	logic [15:0] reg_value;
	logic [15:0] read_data;
	logic        halted;

	logic [15:0] model_mem [0:MEM_WORDS-1];
	logic [15:0] model_regs [0:NUM_REGS-1];
	logic [15:0] model_pc;
	logic [2:0]  model_flags;

	outcome_t    predicted_outcomes [$];
	outcome_t    oldest_outcome;
	int unsigned items_sent;
	int unsigned results_checked;
	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned idle_pct;
	int unsigned stall_pct;

	lc3b_instruction_step dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.mem_addr(mem_addr),
		.mem_data(mem_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pc_now(pc_now),
		.cond_flags(cond_flags),
		.reg_written(reg_written),
		.reg_index(reg_index),
		.reg_value(reg_value),
		.read_data(read_data),
		.halted(halted)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
				predicted_outcomes.size());
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < stall_pct);
	end

	function automatic logic [15:0] sext(logic [15:0] v, int bits);
		logic [15:0] m;
		m = (16'd1 << bits) - 16'd1;
		v = v & m;
		if (v[bits-1])
			v = v | ~m;
		return v;
	endfunction

	function automatic int mem_index(logic [15:0] byte_addr);
		return int'(byte_addr >> 1) % MEM_WORDS;
	endfunction

	function automatic outcome_t isa_execute(req_t req, logic [14:0] addr, logic [15:0] data);
		outcome_t o;
		logic [15:0] ir, npc, s1, s2, opnd, ea, rv, w;
		logic [3:0] op;
		logic [2:0] dr;
		logic wr;
		o = '0;
		wr = 1'b0;
		rv = '0;
		case (req)
		REQ_WRITE: model_mem[int'(addr) % MEM_WORDS] = data;
		REQ_READ: o.read_data = model_mem[int'(addr) % MEM_WORDS];
		REQ_SETPC: begin
			model_pc = data;
			model_flags = FLAGS_Z;
		end
		default: begin
			if (model_pc == 16'd0) begin
				o.halted = 1'b1;
			end else begin
				ir = model_mem[mem_index(model_pc)];
				npc = model_pc + 16'd2;
				op = ir[15:12];
				dr = ir[11:9];
				s1 = model_regs[ir[8:6]];
				s2 = model_regs[ir[2:0]];
				opnd = ir[5] ? sext(ir, 5) : s2;
				o.read_data = ir;
				case (op)
				OP_ADD: begin
					wr = 1'b1;
					rv = s1 + opnd;
				end
				OP_AND: begin
					wr = 1'b1;
					rv = s1 & opnd;
				end
				OP_XOR: begin
					wr = 1'b1;
					rv = s1 ^ opnd;
				end
				OP_SHF: begin
					wr = 1'b1;
					if (!ir[4])
						rv = s1 << ir[3:0];
					else if (!ir[5])
						rv = s1 >> ir[3:0];
					else
						rv = 16'($signed(s1) >>> ir[3:0]);
				end
				OP_BR: begin
					if ((ir[11:9] & model_flags) != 3'd0)
						npc = npc + (sext(ir, 9) << 1);
				end
				OP_JMP: npc = s1;
				OP_JSR: begin
					wr = 1'b1;
					dr = LINK_REG;
					rv = npc;
					npc = ir[11] ? npc + (sext(ir, 11) << 1) : s1;
				end
				OP_LEA: begin
					wr = 1'b1;
					rv = npc + (sext(ir, 9) << 1);
				end
				OP_LDB: begin
					ea = s1 + sext(ir, 6);
					w = model_mem[mem_index(ea)];
					wr = 1'b1;
					rv = sext({8'h00, ea[0] ? w[15:8] : w[7:0]}, 8);
				end
				OP_LDW: begin
					ea = s1 + (sext(ir, 6) << 1);
					wr = 1'b1;
					rv = model_mem[mem_index(ea)];
				end
				OP_STB: begin
					ea = s1 + sext(ir, 6);
					if (ea[0])
						model_mem[mem_index(ea)][15:8] = model_regs[dr][7:0];
					else
						model_mem[mem_index(ea)][7:0] = model_regs[dr][7:0];
				end
				OP_STW: begin
					ea = s1 + (sext(ir, 6) << 1);
					model_mem[mem_index(ea)] = model_regs[dr];
				end
				OP_TRAP: begin
					wr = 1'b1;
					dr = LINK_REG;
					rv = npc;
					npc = model_mem[int'(ir[7:0]) % MEM_WORDS];
				end
				default: ;
				endcase
				if (wr) begin
					model_regs[dr] = rv;
					o.reg_written = 1'b1;
					o.reg_index = dr;
					o.reg_value = rv;
					if (op != OP_LEA && op != OP_JSR && op != OP_TRAP)
						model_flags = rv[15] ? FLAGS_N : (rv == 16'd0 ? FLAGS_Z : FLAGS_P);
				end
				model_pc = npc;
			end
		end
		endcase
		o.pc_now = model_pc;
		o.cond_flags = model_flags;
		return o;
	endfunction

	function automatic void compare_field(string name, logic [15:0] exp, logic [15:0] act);
		if (exp !== act) begin
			$error("%s: expected %h, got %h", name, exp, act);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (predicted_outcomes.size() == 0) begin
				$error("result transfer with no request outstanding");
				mismatch_count++;
			end else begin
				oldest_outcome = predicted_outcomes.pop_front();
				results_checked++;
				compare_field("pc_now", oldest_outcome.pc_now, pc_now);
				compare_field("cond_flags", 16'(oldest_outcome.cond_flags), 16'(cond_flags));
				compare_field("reg_written", 16'(oldest_outcome.reg_written), 16'(reg_written));
				compare_field("reg_index", 16'(oldest_outcome.reg_index), 16'(reg_index));
				compare_field("reg_value", oldest_outcome.reg_value, reg_value);
				compare_field("read_data", oldest_outcome.read_data, read_data);
				compare_field("halted", 16'(oldest_outcome.halted), 16'(halted));
			end
		end
	end

	task automatic send_request(req_t req, logic [14:0] addr, logic [15:0] data);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		req_type = req;
		mem_addr = addr;
		mem_data = data;
		do
			@(posedge clk);
		while (in_stall);
		predicted_outcomes.push_back(isa_execute(req, addr, data));
		items_sent++;
	endtask

	task automatic set_idling(int unsigned idle, int unsigned stall);
		idle_pct = idle;
		stall_pct = stall;
	endtask

	task automatic test_memory_requests();
		send_request(REQ_WRITE, 15'h7FFF, 16'hFFFF);
		send_request(REQ_WRITE, 15'h0000, 16'h0000);
		send_request(REQ_READ, 15'h7FFF, 16'h0000);
		send_request(REQ_READ, 15'h1234, 16'hFFFF);
	endtask

	task automatic test_halt();
		send_request(REQ_EXEC, 15'h0000, 16'h0000);
		// odd pc at the top of memory fetches the TRAP word written above
		send_request(REQ_SETPC, 15'h7FFF, 16'hFFFF);
		send_request(REQ_EXEC, 15'h7FFF, 16'hFFFF);
		send_request(REQ_EXEC, 15'h0000, 16'h0000);
	endtask

	task automatic test_directed_program();
		logic [15:0] prog [10];
		logic [14:0] base;
		base = 15'h0080;
		prog[0] = {OP_ADD, 3'd1, 3'd0, 1'b1, 5'b10000};
		prog[1] = {OP_XOR, 3'd2, 3'd1, 1'b1, 5'b11111};
		prog[2] = {OP_SHF, 3'd3, 3'd1, 2'b11, 4'd15};
		prog[3] = {OP_SHF, 3'd3, 3'd2, 2'b10, 4'd12};
		prog[4] = {OP_LEA, 3'd4, 9'h1FF};
		prog[5] = {OP_STB, 3'd1, 3'd4, 6'd1};
		prog[6] = {OP_LDB, 3'd5, 3'd4, 6'd1};
		prog[7] = {OP_BR, 3'b000, 9'h1FF};
		prog[8] = {OP_RTI, 12'hFFF};
		prog[9] = {OP_JSR, 1'b0, 2'b00, LINK_REG, 6'd0};
		for (int i = 0; i < 10; i++)
			send_request(REQ_WRITE, base + 15'(i), prog[i]);
		send_request(REQ_SETPC, 15'h0000, {base, 1'b0});
		for (int i = 0; i < 11; i++)
			send_request(REQ_EXEC, 15'h0000, 16'h0000);
	endtask

	function automatic logic [15:0] random_instruction();
		logic [15:0] ir;
		ir = 16'($urandom);
		case ($urandom_range(7))
		0: ir[15:12] = OP_RSV_A;
		1: ir[15:12] = OP_RSV_B;
		2: ir[11:9] = 3'b111;
		default: ;
		endcase
		return ir;
	endfunction

	task automatic test_random_traffic(int unsigned budget);
		int unsigned stop_at, pick, n;
		logic [14:0] base;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				n = $urandom_range(8, 1);
				base = 15'($urandom_range(32767 - n, 1));
				for (int i = 0; i < n; i++)
					send_request(REQ_WRITE, base + 15'(i), random_instruction());
				send_request(REQ_SETPC, 15'($urandom), {base, 1'($urandom_range(1))});
				for (int i = 0; i < n; i++)
					send_request(REQ_EXEC, 15'($urandom), 16'($urandom));
			end else if (pick < 75) begin
				// low words double as trap vectors
				base = $urandom_range(1) ? 15'($urandom_range(255)) : 15'($urandom);
				send_request(REQ_WRITE, base, 16'($urandom));
			end else if (pick < 85) begin
				base = $urandom_range(1) ? 15'($urandom_range(255)) : 15'($urandom);
				send_request(REQ_READ, base, 16'($urandom));
			end else begin
				send_request(req_t'($urandom_range(3)), 15'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_WRITE;
		mem_addr = '0;
		mem_data = '0;
		out_stall = 1'b0;
		items_sent = 0;
		results_checked = 0;
		mismatch_count = 0;
		cycle_count = 0;
		set_idling(0, 0);
		for (int i = 0; i < MEM_WORDS; i++)
			model_mem[i] = '0;
		for (int i = 0; i < NUM_REGS; i++)
			model_regs[i] = '0;
		model_pc = '0;
		model_flags = FLAGS_Z;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_memory_requests();
		test_halt();
		test_directed_program();
		set_idling(0, 0);
		test_random_traffic(ITEMS_PER_PHASE);
		set_idling(81, 0);
		test_random_traffic(ITEMS_PER_PHASE);
		set_idling(0, 81);
		test_random_traffic(ITEMS_PER_PHASE);
		set_idling(14, 14);
		test_random_traffic(ITEMS_PER_PHASE);

		@(negedge clk);
		in_valid = 1'b0;
		while (predicted_outcomes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Run covered %0d requests (memory, set-pc, halt and random programs)", items_sent);
		$display("with %0d results checked under four idle/stall mixes", results_checked);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
